// File: rtl/core/cfa_pkg.sv
package cfa_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_DESIRED_SPEED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_ACCELERATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_TERM_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STANDSTILL_GAP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_HEADWAY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_FLOOR         = 3'd5;

    localparam logic [30:0] RST_DESIRED_SPEED     = 31'd917504;
    localparam logic [30:0] RST_PEAK_ACCELERATION = 31'd65536;
    localparam logic [30:0] RST_BRAKE_TERM_SCALE  = 31'd26755;
    localparam logic [30:0] RST_STANDSTILL_GAP    = 31'd131072;
    localparam logic [30:0] RST_TIME_HEADWAY      = 31'd98304;
    localparam logic [30:0] RST_GAP_FLOOR         = 31'd6554;

    localparam int FRONT_LAT = 6;
    localparam int QUO_BITS  = 32;
    localparam int DIV_LAT   = QUO_BITS + 2;
    localparam int BACK_LAT  = 9;

    localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic [30:0]        own_velocity;
        logic signed [31:0] own_position;
        logic [30:0]        speed_limit;
        logic               lead_present;
        logic [30:0]        lead_velocity;
        logic signed [31:0] lead_position;
        logic [30:0]        lead_length;
    } t_car_in;

    typedef struct packed {
        logic signed [31:0] acceleration;
        logic [30:0]        new_velocity;
        logic signed [31:0] new_position;
    } t_car_out;

    typedef struct packed {
        logic [30:0] desired_speed;
        logic [30:0] peak_acceleration;
        logic [30:0] brake_term_scale;
        logic [30:0] standstill_gap;
        logic [30:0] time_headway;
        logic [30:0] gap_floor;
    } t_cfg;

    typedef struct packed {
        logic [30:0]        own_velocity;
        logic signed [31:0] own_position;
        logic               lead_present;
    } t_side;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > S32_MAX) begin
            return S32_MAX[31:0];
        end else if (x < S32_MIN) begin
            return S32_MIN[31:0];
        end else begin
            return x[31:0];
        end
    endfunction

    function automatic logic signed [31:0] mulsh(input logic signed [63:0] p, input int frac);
        logic signed [63:0] s;
        s = p >>> frac;
        return sat32(s);
    endfunction

endpackage

// File: rtl/core/cfa_front.sv
module cfa_front import cfa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  t_car_in            i_car,
    input  t_cfg               i_cfg,
    output logic               o_vld,
    output t_side              o_side,
    output logic [30:0]        o_target,
    output logic [30:0]        o_gap,
    output logic signed [31:0] o_num
);

    logic [FRONT_LAT-1:0] r_vld;

    t_car_in            r_f1_car;
    t_side              r_f2_side, r_f3_side, r_f4_side, r_f5_side, r_f6_side;
    logic [30:0]        r_f2_target, r_f3_target, r_f4_target, r_f5_target, r_f6_target;
    logic [30:0]        r_f2_gap, r_f3_gap, r_f4_gap, r_f5_gap, r_f6_gap;
    logic signed [31:0] r_f2_dv;
    logic signed [63:0] r_f3_vt_p, r_f3_vdv_p;
    logic signed [31:0] r_f4_vt, r_f4_vdv;
    logic signed [63:0] r_f5_k_p;
    logic signed [31:0] r_f5_num1;
    logic signed [31:0] r_f6_num;

    logic signed [33:0] n_gap_raw;
    logic signed [33:0] n_gap_floor;
    logic signed [33:0] n_gap_held;
    logic [30:0]        n_gap;

    always_comb begin
        n_gap_raw   = {{2{r_f1_car.lead_position[31]}}, r_f1_car.lead_position}
                    - {{2{r_f1_car.own_position[31]}}, r_f1_car.own_position}
                    - $signed({3'b000, r_f1_car.lead_length});
        n_gap_floor = $signed({3'b000, i_cfg.gap_floor});
        n_gap_held  = (n_gap_raw < n_gap_floor) ? n_gap_floor : n_gap_raw;
        n_gap       = (n_gap_held > $signed(34'h0_7FFF_FFFF)) ? 31'h7FFF_FFFF
                                                              : n_gap_held[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRONT_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_car <= i_car;

        r_f2_side   <= '{own_velocity: r_f1_car.own_velocity,
                         own_position: r_f1_car.own_position,
                         lead_present: r_f1_car.lead_present};
        r_f2_target <= (r_f1_car.speed_limit < i_cfg.desired_speed) ? r_f1_car.speed_limit
                                                                    : i_cfg.desired_speed;
        r_f2_gap    <= n_gap;
        r_f2_dv     <= $signed({1'b0, r_f1_car.own_velocity})
                     - $signed({1'b0, r_f1_car.lead_velocity});

        r_f3_side   <= r_f2_side;
        r_f3_target <= r_f2_target;
        r_f3_gap    <= r_f2_gap;
        r_f3_vt_p   <= $signed({1'b0, r_f2_side.own_velocity})
                     * $signed({1'b0, i_cfg.time_headway});
        r_f3_vdv_p  <= $signed({1'b0, r_f2_side.own_velocity}) * r_f2_dv;

        r_f4_side   <= r_f3_side;
        r_f4_target <= r_f3_target;
        r_f4_gap    <= r_f3_gap;
        r_f4_vt     <= mulsh(r_f3_vt_p, FRAC_BITS);
        r_f4_vdv    <= mulsh(r_f3_vdv_p, FRAC_BITS);

        r_f5_side   <= r_f4_side;
        r_f5_target <= r_f4_target;
        r_f5_gap    <= r_f4_gap;
        r_f5_k_p    <= r_f4_vdv * $signed({1'b0, i_cfg.brake_term_scale});
        r_f5_num1   <= sat32($signed({33'd0, i_cfg.standstill_gap})
                     + {{32{r_f4_vt[31]}}, r_f4_vt});

        r_f6_side   <= r_f5_side;
        r_f6_target <= r_f5_target;
        r_f6_gap    <= r_f5_gap;
        r_f6_num    <= sat32({{32{r_f5_num1[31]}}, r_f5_num1}
                     + 64'(mulsh(r_f5_k_p, FRAC_BITS)));
    end

    assign o_vld    = r_vld[FRONT_LAT-1];
    assign o_side   = r_f6_side;
    assign o_target = r_f6_target;
    assign o_gap    = r_f6_gap;
    assign o_num    = r_f6_num;

endmodule

// File: rtl/core/cfa_div.sv
module cfa_div import cfa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic signed [31:0] i_num,
    input  logic [30:0]        i_den,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_vld,
    output logic signed [31:0] o_quo,
    output logic [SIDE_W-1:0]  o_side
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = NW + QUO_BITS;

    logic [NW-1:0]       r_rem  [0:QUO_BITS];
    logic [QUO_BITS-1:0] r_quo  [0:QUO_BITS];
    logic [30:0]         r_den  [0:QUO_BITS];
    logic                r_neg  [0:QUO_BITS];
    logic                r_ovf  [0:QUO_BITS];
    logic                r_nz   [0:QUO_BITS];
    logic [SIDE_W-1:0]   r_side [0:QUO_BITS];
    logic [QUO_BITS:0]   r_vld;
    logic                r_out_vld;
    logic signed [31:0]  r_out_quo;
    logic [SIDE_W-1:0]   r_out_side;

    logic [31:0]        n_mag;
    logic [NW-1:0]      n_nmag;
    logic signed [31:0] n_quo;
    logic [QUO_BITS-1:0] n_q;

    always_comb begin
        n_mag  = i_num[31] ? (~i_num + 32'd1) : i_num;
        n_nmag = {n_mag, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_nmag;
        r_quo[0]  <= '0;
        r_den[0]  <= i_den;
        r_neg[0]  <= i_num[31];
        r_nz[0]   <= (i_num != 32'sd0);
        r_ovf[0]  <= (32'(n_nmag >> QUO_BITS) >= {1'b0, i_den});
        r_side[0] <= i_side;
    end

    for (genvar j = 1; j <= QUO_BITS; j++) begin : g_step
        localparam int BIT = QUO_BITS - j;
        logic [CW-1:0]       n_diff;
        logic [QUO_BITS-1:0] n_qb;
        always_comb begin
            n_diff = CW'(r_rem[j-1]) - (CW'(r_den[j-1]) << BIT);
            n_qb   = r_quo[j-1];
            n_qb[BIT] = ~n_diff[CW-1];
        end
        always_ff @(posedge i_clk) begin
            r_rem[j]  <= n_diff[CW-1] ? r_rem[j-1] : n_diff[NW-1:0];
            r_quo[j]  <= n_qb;
            r_den[j]  <= r_den[j-1];
            r_neg[j]  <= r_neg[j-1];
            r_nz[j]   <= r_nz[j-1];
            r_ovf[j]  <= r_ovf[j-1];
            r_side[j] <= r_side[j-1];
        end
    end

    always_comb begin
        n_q = r_quo[QUO_BITS];
        if (!r_nz[QUO_BITS]) begin
            n_quo = 32'sd0;
        end else if (r_ovf[QUO_BITS]) begin
            n_quo = r_neg[QUO_BITS] ? S32_MIN[31:0] : S32_MAX[31:0];
        end else if (r_neg[QUO_BITS]) begin
            n_quo = (n_q > 32'h8000_0000) ? S32_MIN[31:0] : $signed(~n_q + 32'd1);
        end else begin
            n_quo = (n_q > 32'h7FFF_FFFF) ? S32_MAX[31:0] : $signed(n_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[QUO_BITS-1:0], i_vld};
            r_out_vld <= r_vld[QUO_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_quo  <= n_quo;
        r_out_side <= r_side[QUO_BITS];
    end

    assign o_vld  = r_out_vld;
    assign o_quo  = r_out_quo;
    assign o_side = r_out_side;

endmodule

// File: rtl/core/cfa_back.sv
module cfa_back import cfa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  t_side              i_side,
    input  logic signed [31:0] i_q,
    input  logic signed [31:0] i_ratio,
    input  logic [30:0]        i_peak,
    output logic               o_vld,
    output t_car_out           o_result
);

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    logic [BACK_LAT-1:0] r_vld;
    t_side               r_side [1:BACK_LAT];

    logic signed [63:0] r_b1_q2_p, r_b1_r2_p;
    logic signed [31:0] r_b2_q2, r_b2_lt;
    logic signed [63:0] r_b3_q4_p;
    logic signed [31:0] r_b3_lt;
    logic signed [31:0] r_b4_free, r_b4_lt;
    logic signed [31:0] r_b5_diff;
    logic signed [63:0] r_b6_acc_p;
    logic signed [31:0] r_b7_acc, r_b8_acc, r_b9_acc;
    logic [30:0]        r_b8_nv, r_b9_nv;
    logic signed [31:0] r_b9_np;

    logic signed [33:0] n_nv_sum;
    logic [30:0]        n_nv;

    always_comb begin
        n_nv_sum = $signed({3'b000, r_side[7].own_velocity}) + {{2{r_b7_acc[31]}}, r_b7_acc};
        if (n_nv_sum[33]) begin
            n_nv = '0;
        end else if (n_nv_sum > $signed(34'h0_7FFF_FFFF)) begin
            n_nv = 31'h7FFF_FFFF;
        end else begin
            n_nv = n_nv_sum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[BACK_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[1] <= i_side;
        for (int k = 2; k <= BACK_LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end

        r_b1_q2_p  <= i_q * i_q;
        r_b1_r2_p  <= i_ratio * i_ratio;

        r_b2_q2    <= mulsh(r_b1_q2_p, FRAC_BITS);
        r_b2_lt    <= r_side[1].lead_present ? mulsh(r_b1_r2_p, FRAC_BITS) : 32'sd0;

        r_b3_q4_p  <= r_b2_q2 * r_b2_q2;
        r_b3_lt    <= r_b2_lt;

        r_b4_free  <= sat32(ONE - 64'(mulsh(r_b3_q4_p, FRAC_BITS)));
        r_b4_lt    <= r_b3_lt;

        r_b5_diff  <= sat32(64'(r_b4_free) - 64'(r_b4_lt));

        r_b6_acc_p <= $signed({1'b0, i_peak}) * r_b5_diff;

        r_b7_acc   <= mulsh(r_b6_acc_p, FRAC_BITS);

        r_b8_acc   <= r_b7_acc;
        r_b8_nv    <= n_nv;

        r_b9_acc   <= r_b8_acc;
        r_b9_nv    <= r_b8_nv;
        r_b9_np    <= sat32(64'(r_side[8].own_position) + $signed({33'd0, r_b8_nv}));
    end

    assign o_vld                 = r_vld[BACK_LAT-1];
    assign o_result.acceleration = r_b9_acc;
    assign o_result.new_velocity = r_b9_nv;
    assign o_result.new_position = r_b9_np;

endmodule

// File: rtl/core/car_following_acceleration_step_unit.sv
// Car-following acceleration step. Each beat on start (taken whenever busy is low; busy is high
// only while reset is held) carries one car; its result is marked by o_done for one cycle, in
// the order the cars went in. A new car may enter every cycle. The pipeline is made of the two
// 32-stage restoring dividers (speed ratio and gap ratio), one quotient bit per stage, plus six
// front stages and nine back stages of multiply, shift and saturate. The receiver cannot stall:
// results must be taken as they come. The user must write the configuration registers through
// i_cfg_we / i_cfg_idx / i_cfg_data only while no car is in flight; the block does not check.
module car_following_acceleration_step_unit import cfa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_car_in               i_car,
    output logic                  o_done,
    output t_car_out              o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PIPE_LAT = FRONT_LAT + DIV_LAT + BACK_LAT;

    t_cfg               r_cfg;
    logic               n_take;
    logic               f_vld;
    t_side              f_side;
    logic [30:0]        f_target, f_gap;
    logic signed [31:0] f_num;
    logic               d_vld;
    logic               g_vld;
    logic signed [31:0] d_q, d_ratio;
    logic [62:0]        d_side_q;
    logic               d_lead;
    t_side              d_side;

    assign busy   = ~i_rst_n;
    assign n_take = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{desired_speed:     RST_DESIRED_SPEED,
                       peak_acceleration: RST_PEAK_ACCELERATION,
                       brake_term_scale:  RST_BRAKE_TERM_SCALE,
                       standstill_gap:    RST_STANDSTILL_GAP,
                       time_headway:      RST_TIME_HEADWAY,
                       gap_floor:         RST_GAP_FLOOR};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DESIRED_SPEED:     r_cfg.desired_speed     <= i_cfg_data;
                CFG_PEAK_ACCELERATION: r_cfg.peak_acceleration <= i_cfg_data;
                CFG_BRAKE_TERM_SCALE:  r_cfg.brake_term_scale  <= i_cfg_data;
                CFG_STANDSTILL_GAP:    r_cfg.standstill_gap    <= i_cfg_data;
                CFG_TIME_HEADWAY:      r_cfg.time_headway      <= i_cfg_data;
                CFG_GAP_FLOOR:         r_cfg.gap_floor         <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cfa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (n_take),
        .i_car    (i_car),
        .i_cfg    (r_cfg),
        .o_vld    (f_vld),
        .o_side   (f_side),
        .o_target (f_target),
        .o_gap    (f_gap),
        .o_num    (f_num)
    );

    cfa_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(63)) u_div_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_num   ($signed({1'b0, f_side.own_velocity})),
        .i_den   (f_target),
        .i_side  ({f_side.own_velocity, f_side.own_position}),
        .o_vld   (d_vld),
        .o_quo   (d_q),
        .o_side  (d_side_q)
    );

    cfa_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_gap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_num   (f_num),
        .i_den   (f_gap),
        .i_side  (f_side.lead_present),
        .o_vld   (g_vld),
        .o_quo   (d_ratio),
        .o_side  (d_lead)
    );

    assign d_side = '{own_velocity: d_side_q[62:32],
                      own_position: $signed(d_side_q[31:0]),
                      lead_present: d_lead};

    cfa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (d_vld),
        .i_side   (d_side),
        .i_q      (d_q),
        .i_ratio  (d_ratio),
        .i_peak   (r_cfg.peak_acceleration),
        .o_vld    (o_done),
        .o_result (o_result)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_take |-> ##PIPE_LAT o_done)
        else $error("accepted beat did not complete on schedule");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !n_take |-> ##PIPE_LAT !o_done)
        else $error("result without an accepted beat");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    a_div_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        g_vld == d_vld)
        else $error("divider outputs out of step");

    a_accel_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.acceleration[31] && o_result.acceleration != 32'sd0)
        |-> o_result.new_velocity != 31'd0)
        else $error("positive acceleration left the car at rest");

endmodule
